// ----- design/humidity_sensor_read_sequencer_top_assert.svh -----
// Assertion macros shared by the checker of the sensor read sequencer.
// Holds macro definitions only; no dependencies.
`ifndef HUMIDITY_SENSOR_READ_SEQUENCER_TOP_ASSERT_SVH
`define HUMIDITY_SENSOR_READ_SEQUENCER_TOP_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define HSRS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds in the cycle after a condition.
`define HSRS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

// ----- design/hsrs_pkg.sv -----
// Shared types and constants of the sensor read sequencer.
// No dependencies.
package hsrs_pkg;

    // input command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_DONE  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic KIND_REQ    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [1:0] OUTCOME_OK      = 2'd0;
    localparam logic [1:0] OUTCOME_ERROR   = 2'd1;
    localparam logic [1:0] OUTCOME_TIMEOUT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_SETTLE_WAIT    = 2'd1;
    localparam logic [1:0] CFG_POLL_INTERVAL  = 2'd2;
    localparam logic [1:0] CFG_MAX_POLLS      = 2'd3;

    localparam logic [6:0] RST_DEVICE_ADDRESS = 7'd56;
    localparam logic [7:0] RST_SETTLE_WAIT    = 8'd80;
    localparam logic [7:0] RST_POLL_INTERVAL  = 8'd10;
    localparam logic [3:0] RST_MAX_POLLS      = 4'd10;

    // sensor command bytes
    localparam logic [23:0] STATUS_CMD_BYTES  = 24'h000071;
    localparam logic [23:0] TRIGGER_BYTES     = 24'h0033AC;
    localparam logic [2:0]  LEN_STATUS        = 3'd1;
    localparam logic [2:0]  LEN_TRIGGER       = 3'd3;
    localparam logic [2:0]  LEN_DATA          = 3'd6;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] settle_wait;
        logic [7:0] poll_interval;
        logic [3:0] max_polls;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic        is_read;
        logic [2:0]  length;
        logic [6:0]  address;
        logic [23:0] write_bytes;
        logic [1:0]  outcome;
        logic        meas;
    } t_req;

endpackage

// ----- design/hsrs_ctrl.sv -----
// Sequencer state machine: phase, tick counter and poll counter.
// Depends on hsrs_pkg for command codes and the result header type.
module hsrs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [1:0]          i_cmd,
    input  logic                i_xfer_ok,
    input  logic                i_status_busy,
    input  hsrs_pkg::t_cfg      i_cfg,
    output logic                o_has_result,
    output hsrs_pkg::t_req      o_req
);
    import hsrs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_STW, PH_STR, PH_TRIG, PH_WAIT, PH_PLW, PH_PLR, PH_DATA
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_tick, n_tick;
    logic [3:0] r_polls, n_polls;
    logic [7:0] w_tick_dec;
    logic [3:0] w_polls_inc;

    assign w_tick_dec  = r_tick - 8'd1;
    assign w_polls_inc = r_polls + 4'd1;

    function automatic t_req mk_req(input logic rd, input logic [2:0] len,
                                    input logic [23:0] wb, input logic [6:0] addr);
        t_req r;
        r             = '0;
        r.kind        = KIND_REQ;
        r.is_read     = rd;
        r.length      = len;
        r.address     = addr;
        r.write_bytes = wb;
        return r;
    endfunction

    function automatic t_req mk_report(input logic [1:0] code);
        t_req r;
        r         = '0;
        r.kind    = KIND_REPORT;
        r.outcome = code;
        r.meas    = (code == OUTCOME_OK);
        return r;
    endfunction

    always_comb begin
        n_phase      = r_phase;
        n_tick       = r_tick;
        n_polls      = r_polls;
        o_has_result = 1'b0;
        o_req        = '0;
        if (i_fire) begin
            unique case (i_cmd)
                CMD_START: begin
                    if (r_phase == PH_IDLE) begin
                        n_phase      = PH_STW;
                        o_has_result = 1'b1;
                        o_req        = mk_req(1'b0, LEN_STATUS, STATUS_CMD_BYTES,
                                              i_cfg.device_address);
                    end
                end
                CMD_TICK: begin
                    if (r_phase == PH_WAIT) begin
                        n_tick = w_tick_dec;
                        if (w_tick_dec == 8'd0) begin
                            n_phase      = PH_PLW;
                            o_has_result = 1'b1;
                            o_req        = mk_req(1'b0, LEN_STATUS, STATUS_CMD_BYTES,
                                                  i_cfg.device_address);
                        end
                    end
                end
                CMD_DONE: begin
                    if (r_phase != PH_IDLE && r_phase != PH_WAIT) begin
                        o_has_result = 1'b1;
                        if (!i_xfer_ok) begin
                            n_phase = PH_IDLE;
                            o_req   = mk_report(OUTCOME_ERROR);
                        end else begin
                            unique case (r_phase)
                                PH_STW: begin
                                    n_phase = PH_STR;
                                    o_req   = mk_req(1'b1, LEN_STATUS, 24'd0,
                                                     i_cfg.device_address);
                                end
                                PH_STR: begin
                                    n_phase = PH_TRIG;
                                    o_req   = mk_req(1'b0, LEN_TRIGGER, TRIGGER_BYTES,
                                                     i_cfg.device_address);
                                end
                                PH_TRIG: begin
                                    n_polls = 4'd0;
                                    n_tick  = i_cfg.settle_wait;
                                    if (i_cfg.settle_wait == 8'd0) begin
                                        n_phase = PH_PLW;
                                        o_req   = mk_req(1'b0, LEN_STATUS,
                                                         STATUS_CMD_BYTES,
                                                         i_cfg.device_address);
                                    end else begin
                                        n_phase      = PH_WAIT;
                                        o_has_result = 1'b0;
                                    end
                                end
                                PH_PLW: begin
                                    n_phase = PH_PLR;
                                    o_req   = mk_req(1'b1, LEN_STATUS, 24'd0,
                                                     i_cfg.device_address);
                                end
                                PH_PLR: begin
                                    if (!i_status_busy) begin
                                        n_phase = PH_DATA;
                                        o_req   = mk_req(1'b1, LEN_DATA, 24'd0,
                                                         i_cfg.device_address);
                                    end else begin
                                        n_polls = w_polls_inc;
                                        if (w_polls_inc == 4'd0 ||
                                            w_polls_inc >= i_cfg.max_polls) begin
                                            n_phase = PH_IDLE;
                                            o_req   = mk_report(OUTCOME_TIMEOUT);
                                        end else begin
                                            n_tick = i_cfg.poll_interval;
                                            if (i_cfg.poll_interval == 8'd0) begin
                                                n_phase = PH_PLW;
                                                o_req   = mk_req(1'b0, LEN_STATUS,
                                                                 STATUS_CMD_BYTES,
                                                                 i_cfg.device_address);
                                            end else begin
                                                n_phase      = PH_WAIT;
                                                o_has_result = 1'b0;
                                            end
                                        end
                                    end
                                end
                                PH_DATA: begin
                                    n_phase = PH_IDLE;
                                    o_req   = mk_report(OUTCOME_OK);
                                end
                                default: begin
                                    o_has_result = 1'b0;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= 8'd0;
            r_polls <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_polls <= n_polls;
        end
    end

endmodule

// ----- design/hsrs_conv.sv -----
// Result pipeline: carries the result header and converts raw readings
// to tenths and whole-unit bytes over four stages. Depends on hsrs_pkg.
module hsrs_conv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hsrs_pkg::t_req      i_req,
    input  logic [47:0]         i_read_bytes,
    output logic                o_valid,
    input  logic                i_stall,
    output hsrs_pkg::t_req      o_req,
    output logic [9:0]          o_humidity_tenths,
    output logic signed [11:0]  o_celsius_tenths,
    output logic signed [12:0]  o_fahrenheit_tenths,
    output logic [7:0]          o_frame_humidity_byte,
    output logic [7:0]          o_frame_celsius_byte,
    output logic [7:0]          o_frame_fahrenheit_byte
);
    import hsrs_pkg::*;

    // 500 * 2^20, the offset of the temperature formula
    localparam logic [32:0] TEMP_OFFSET = 33'd524288000;
    // 9/5 scaled by 2^18
    localparam logic [29:0] NINE_FIFTHS = 30'd471861;

    // floor(x/10) by reciprocal, exact over 12-bit inputs
    function automatic logic [8:0] div10(input logic [11:0] x);
        logic [28:0] p;
        p = {17'd0, x} * 29'd52429;
        return p[27:19];
    endfunction

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    // stage 1: header and scaled raw values
    t_req        r1_req;
    logic [29:0] r1_hprod;
    logic [30:0] r1_tprod;
    logic [19:0] w_hraw, w_traw;

    // stage 2: humidity tenths, Celsius sign and magnitude
    t_req        r2_req;
    logic [9:0]  r2_rh;
    logic        r2_neg;
    logic [10:0] r2_mag;
    logic [32:0] w_num, w_abs;

    // stage 3
    t_req        r3_req;
    logic [9:0]  r3_rh;
    logic [11:0] r3_tc;
    logic [12:0] r3_tf;
    logic [7:0]  r3_rhb, r3_tcb;
    logic [29:0] w_q9p;
    logic [11:0] w_q9;
    logic [8:0]  w_rhq, w_tcq;

    // stage 4
    logic [12:0] w_tf_abs;
    logic [8:0]  w_tfq;
    logic [7:0]  w_tfb;

    assign w_rdy4  = !r_v4 || !i_stall;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v4;

    assign w_hraw = {i_read_bytes[15:8], i_read_bytes[23:16], i_read_bytes[31:28]};
    assign w_traw = {i_read_bytes[27:24], i_read_bytes[39:32], i_read_bytes[47:40]};

    assign w_num = {2'b00, r1_tprod} - TEMP_OFFSET;
    assign w_abs = w_num[32] ? (~w_num + 33'd1) : w_num;

    assign w_q9p = {19'd0, r2_mag} * NINE_FIFTHS;
    assign w_q9  = w_q9p[29:18];
    assign w_rhq = div10({2'b00, r2_rh});
    assign w_tcq = div10({1'b0, r2_mag});

    assign w_tf_abs = r3_tf[12] ? (~r3_tf + 13'd1) : r3_tf;
    assign w_tfq    = div10(w_tf_abs[11:0]);
    assign w_tfb    = r3_tf[12] ? (8'd0 - w_tfq[7:0]) : w_tfq[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_req   <= i_req;
            r1_hprod <= {10'd0, w_hraw} * 30'd1000;
            r1_tprod <= {11'd0, w_traw} * 31'd2000;
        end
        if (w_rdy2 && r_v1) begin
            r2_req <= r1_req;
            r2_rh  <= r1_hprod[29:20];
            r2_neg <= w_num[32];
            r2_mag <= w_abs[30:20];
        end
        if (w_rdy3 && r_v2) begin
            r3_req <= r2_req;
            r3_rh  <= r2_rh;
            r3_tc  <= r2_neg ? (12'd0 - {1'b0, r2_mag}) : {1'b0, r2_mag};
            r3_tf  <= r2_neg ? (13'd320 - {1'b0, w_q9}) : (13'd320 + {1'b0, w_q9});
            r3_rhb <= w_rhq[7:0];
            r3_tcb <= r2_neg ? (8'd0 - w_tcq[7:0]) : w_tcq[7:0];
        end
        // drop the measurement on requests and failed reports
        if (w_rdy4 && r_v3) begin
            o_req <= r3_req;
            if (r3_req.meas) begin
                o_humidity_tenths       <= r3_rh;
                o_celsius_tenths        <= r3_tc;
                o_fahrenheit_tenths     <= r3_tf;
                o_frame_humidity_byte   <= r3_rhb;
                o_frame_celsius_byte    <= r3_tcb;
                o_frame_fahrenheit_byte <= w_tfb;
            end else begin
                o_humidity_tenths       <= 10'd0;
                o_celsius_tenths        <= 12'sd0;
                o_fahrenheit_tenths     <= 13'sd0;
                o_frame_humidity_byte   <= 8'd0;
                o_frame_celsius_byte    <= 8'd0;
                o_frame_fahrenheit_byte <= 8'd0;
            end
        end
    end

endmodule

// ----- design/humidity_sensor_read_sequencer_top.sv -----
// Top level of the humidity and temperature sensor read sequencer.
// Depends on hsrs_pkg, hsrs_ctrl and hsrs_conv.
// A result passes through the input register and the four result pipeline stages.
// Throughput: one input transaction per cycle unless o_in_stall holds it; the
// sequencer state is registered and the conversion runs in a four-stage result pipeline.
// Reset clears the sequencer to idle, empties the pipeline and restores the registers.
module humidity_sensor_read_sequencer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_cmd,
    input  logic                i_xfer_ok,
    input  logic [47:0]         i_read_bytes,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_kind,
    output logic                o_req_is_read,
    output logic [2:0]          o_req_length,
    output logic [6:0]          o_req_address,
    output logic [23:0]         o_req_write_bytes,
    output logic [1:0]          o_outcome,
    output logic [9:0]          o_humidity_tenths,
    output logic signed [11:0]  o_celsius_tenths,
    output logic signed [12:0]  o_fahrenheit_tenths,
    output logic [7:0]          o_frame_humidity_byte,
    output logic [7:0]          o_frame_celsius_byte,
    output logic [7:0]          o_frame_fahrenheit_byte,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import hsrs_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic [1:0]  r_cmd;
    logic        r_xfer_ok;
    logic [47:0] r_read_bytes;

    logic        w_conv_ready;
    logic        w_fire;
    logic        w_has_result;
    t_req        w_req;
    t_req        w_out_req;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_in_valid && !w_conv_ready;
    assign w_fire      = r_in_valid && w_conv_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= RST_DEVICE_ADDRESS;
            r_cfg.settle_wait    <= RST_SETTLE_WAIT;
            r_cfg.poll_interval  <= RST_POLL_INTERVAL;
            r_cfg.max_polls      <= RST_MAX_POLLS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg_data[6:0];
                CFG_SETTLE_WAIT:    r_cfg.settle_wait    <= i_cfg_data;
                CFG_POLL_INTERVAL:  r_cfg.poll_interval  <= i_cfg_data;
                CFG_MAX_POLLS:      r_cfg.max_polls      <= i_cfg_data[3:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    // input register; hold while the result pipeline cannot take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_cmd        <= i_cmd;
            r_xfer_ok    <= i_xfer_ok;
            r_read_bytes <= i_read_bytes;
        end
    end

    hsrs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_cmd         (r_cmd),
        .i_xfer_ok     (r_xfer_ok),
        .i_status_busy (r_read_bytes[7]),
        .i_cfg         (r_cfg),
        .o_has_result  (w_has_result),
        .o_req         (w_req)
    );

    hsrs_conv u_conv (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_valid                 (w_fire && w_has_result),
        .o_ready                 (w_conv_ready),
        .i_req                   (w_req),
        .i_read_bytes            (r_read_bytes),
        .o_valid                 (o_out_valid),
        .i_stall                 (i_out_stall),
        .o_req                   (w_out_req),
        .o_humidity_tenths       (o_humidity_tenths),
        .o_celsius_tenths        (o_celsius_tenths),
        .o_fahrenheit_tenths     (o_fahrenheit_tenths),
        .o_frame_humidity_byte   (o_frame_humidity_byte),
        .o_frame_celsius_byte    (o_frame_celsius_byte),
        .o_frame_fahrenheit_byte (o_frame_fahrenheit_byte)
    );

    assign o_kind            = w_out_req.kind;
    assign o_req_is_read     = w_out_req.is_read;
    assign o_req_length      = w_out_req.length;
    assign o_req_address     = w_out_req.address;
    assign o_req_write_bytes = w_out_req.write_bytes;
    assign o_outcome         = w_out_req.outcome;

endmodule

// ----- design/hsrs_checker.sv -----
// Port-level checker for the sensor read sequencer, bound to the top level.
// Depends on humidity_sensor_read_sequencer_top_assert.svh.
`include "humidity_sensor_read_sequencer_top_assert.svh"

module hsrs_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  logic                o_kind,
    input  logic                o_req_is_read,
    input  logic [2:0]          o_req_length,
    input  logic [6:0]          o_req_address,
    input  logic [23:0]         o_req_write_bytes,
    input  logic [1:0]          o_outcome,
    input  logic [9:0]          o_humidity_tenths,
    input  logic signed [11:0]  o_celsius_tenths,
    input  logic signed [12:0]  o_fahrenheit_tenths,
    input  logic [7:0]          o_frame_humidity_byte,
    input  logic [7:0]          o_frame_celsius_byte,
    input  logic [7:0]          o_frame_fahrenheit_byte
);

    `HSRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "stalled result transaction dropped")

    `HSRS_ASSERT(a_req_clean, i_clk, i_rst_n, (o_out_valid && !o_kind) |-> (o_outcome == 2'd0 && o_humidity_tenths == 10'd0 && o_frame_fahrenheit_byte == 8'd0 && (o_req_length == 3'd1 || o_req_length == 3'd3 || o_req_length == 3'd6)), "malformed transfer request")

    `HSRS_ASSERT(a_report_clean, i_clk, i_rst_n, (o_out_valid && o_kind) |-> (!o_req_is_read && o_req_length == 3'd0 && o_req_address == 7'd0 && o_req_write_bytes == 24'd0 && o_outcome != 2'd3), "report carries request fields")

    `HSRS_ASSERT(a_fail_no_meas, i_clk, i_rst_n, (o_out_valid && o_kind && o_outcome != 2'd0) |-> (o_humidity_tenths == 10'd0 && o_celsius_tenths == 12'sd0 && o_fahrenheit_tenths == 13'sd0 && o_frame_celsius_byte == 8'd0), "failed report carries a measurement")

endmodule

bind humidity_sensor_read_sequencer_top hsrs_checker u_hsrs_checker (.*);

// ----- dv/humidity_sensor_read_sequencer_top_test.sv -----
// Self-checking testbench for the humidity sensor read sequencer top level.
// Drives sensor events and register writes, predicts every request and report,
// and compares each output transaction field by field. Depends on hsrs_pkg.
module humidity_sensor_read_sequencer_top_test;
    import hsrs_pkg::*;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        ok;
        logic [47:0] payload;
    } t_sensor_event;

    typedef struct packed {
        logic               kind;
        logic               is_read;
        logic [2:0]         length;
        logic [6:0]         address;
        logic [23:0]        write_bytes;
        logic [1:0]         outcome;
        logic [9:0]         humidity;
        logic signed [11:0] celsius;
        logic signed [12:0] fahrenheit;
        logic [7:0]         humidity_byte;
        logic [7:0]         celsius_byte;
        logic [7:0]         fahrenheit_byte;
    } t_sensor_reply;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_STATUS_WRITE,
        SEQ_STATUS_READ,
        SEQ_TRIGGER,
        SEQ_WAIT,
        SEQ_POLL_WRITE,
        SEQ_POLL_READ,
        SEQ_DATA
    } t_seq_phase;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_cmd = CMD_NONE;
    logic                i_xfer_ok = 1'b0;
    logic [47:0]         i_read_bytes = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_kind;
    logic                o_req_is_read;
    logic [2:0]          o_req_length;
    logic [6:0]          o_req_address;
    logic [23:0]         o_req_write_bytes;
    logic [1:0]          o_outcome;
    logic [9:0]          o_humidity_tenths;
    logic signed [11:0]  o_celsius_tenths;
    logic signed [12:0]  o_fahrenheit_tenths;
    logic [7:0]          o_frame_humidity_byte;
    logic [7:0]          o_frame_celsius_byte;
    logic [7:0]          o_frame_fahrenheit_byte;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index = CFG_DEVICE_ADDRESS;
    logic [7:0]          i_cfg_data = '0;

    humidity_sensor_read_sequencer_top uut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_in_valid              (i_in_valid),
        .o_in_stall              (o_in_stall),
        .i_cmd                   (i_cmd),
        .i_xfer_ok               (i_xfer_ok),
        .i_read_bytes            (i_read_bytes),
        .o_out_valid             (o_out_valid),
        .i_out_stall             (i_out_stall),
        .o_kind                  (o_kind),
        .o_req_is_read           (o_req_is_read),
        .o_req_length            (o_req_length),
        .o_req_address           (o_req_address),
        .o_req_write_bytes       (o_req_write_bytes),
        .o_outcome               (o_outcome),
        .o_humidity_tenths       (o_humidity_tenths),
        .o_celsius_tenths        (o_celsius_tenths),
        .o_fahrenheit_tenths     (o_fahrenheit_tenths),
        .o_frame_humidity_byte   (o_frame_humidity_byte),
        .o_frame_celsius_byte    (o_frame_celsius_byte),
        .o_frame_fahrenheit_byte (o_frame_fahrenheit_byte),
        .i_cfg_valid             (i_cfg_valid),
        .o_cfg_ready             (o_cfg_ready),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state and its copy of the registers
    t_cfg       seq_cfg = '{RST_DEVICE_ADDRESS, RST_SETTLE_WAIT, RST_POLL_INTERVAL, RST_MAX_POLLS};
    t_seq_phase seq_phase = SEQ_IDLE;
    logic [7:0] ticks_left = '0;
    logic [3:0] busy_polls = '0;

    // settings the stimulus plans its sequences with
    t_cfg plan = '{RST_DEVICE_ADDRESS, RST_SETTLE_WAIT, RST_POLL_INTERVAL, RST_MAX_POLLS};

    t_sensor_event queued_events[$];
    t_sensor_reply predicted_replies[$];
    t_sensor_event offered_event;
    int            events_queued = 0;
    int            events_accepted = 0;
    int            planned_events = 0;
    int            mismatches = 0;
    int            send_gap = 0;
    int            stall_left = 0;
    int            hold_left = 0;
    bit            calm = 1'b0;
    bit            pressure_phase = 1'b0;
    bit            pressure_done = 1'b0;

    function automatic t_sensor_reply request_reply(logic rd, logic [2:0] len,
                                                    logic [23:0] wbytes);
        t_sensor_reply r;
        r = '0;
        r.kind        = KIND_REQ;
        r.is_read     = rd;
        r.length      = len;
        r.address     = seq_cfg.device_address;
        r.write_bytes = wbytes;
        return r;
    endfunction

    function automatic t_sensor_reply end_reading(logic [1:0] code);
        t_sensor_reply r;
        r = '0;
        r.kind    = KIND_REPORT;
        r.outcome = code;
        seq_phase = SEQ_IDLE;
        return r;
    endfunction

    function automatic bit request_poll(output t_sensor_reply res);
        seq_phase = SEQ_POLL_WRITE;
        res = request_reply(1'b0, LEN_STATUS, STATUS_CMD_BYTES);
        return 1'b1;
    endfunction

    function automatic bit begin_wait(logic [7:0] count, output t_sensor_reply res);
        res = '0;
        ticks_left = count;
        // a zero wait goes straight to the next status poll
        if (count == 0)
            return request_poll(res);
        seq_phase = SEQ_WAIT;
        return 1'b0;
    endfunction

    function automatic t_sensor_reply convert_reading(logic [47:0] rb);
        logic [19:0]   hum_raw;
        logic [19:0]   temp_bits;
        longint        scaled;
        int            rh;
        int            tc;
        int            tf;
        t_sensor_reply r;
        hum_raw   = {rb[15:8], rb[23:16], rb[31:28]};
        temp_bits = {rb[27:24], rb[39:32], rb[47:40]};
        scaled = longint'(hum_raw) * 1000;
        rh = int'(scaled >>> 20);
        scaled = longint'(temp_bits) * 2000 - 64'sd524288000;
        // truncate toward zero on both sides of the offset
        if (scaled >= 0)
            tc = int'(scaled >>> 20);
        else
            tc = -int'((-scaled) >>> 20);
        tf = (tc * 9) / 5 + 320;
        r = end_reading(OUTCOME_OK);
        r.humidity        = 10'(rh);
        r.celsius         = 12'(tc);
        r.fahrenheit      = 13'(tf);
        r.humidity_byte   = 8'(rh / 10);
        r.celsius_byte    = 8'(tc / 10);
        r.fahrenheit_byte = 8'(tf / 10);
        return r;
    endfunction

    function automatic bit predict_sequencer_reply(t_sensor_event ev, output t_sensor_reply res);
        res = '0;
        case (ev.cmd)
            CMD_START: begin
                if (seq_phase != SEQ_IDLE)
                    return 1'b0;
                seq_phase = SEQ_STATUS_WRITE;
                res = request_reply(1'b0, LEN_STATUS, STATUS_CMD_BYTES);
                return 1'b1;
            end
            CMD_TICK: begin
                if (seq_phase != SEQ_WAIT)
                    return 1'b0;
                ticks_left = ticks_left - 8'd1;
                if (ticks_left != 0)
                    return 1'b0;
                return request_poll(res);
            end
            CMD_DONE: begin
                if (seq_phase == SEQ_IDLE || seq_phase == SEQ_WAIT)
                    return 1'b0;
                if (!ev.ok) begin
                    res = end_reading(OUTCOME_ERROR);
                    return 1'b1;
                end
                case (seq_phase)
                    SEQ_STATUS_WRITE: begin
                        seq_phase = SEQ_STATUS_READ;
                        res = request_reply(1'b1, LEN_STATUS, '0);
                    end
                    SEQ_STATUS_READ: begin
                        seq_phase = SEQ_TRIGGER;
                        res = request_reply(1'b0, LEN_TRIGGER, TRIGGER_BYTES);
                    end
                    SEQ_TRIGGER: begin
                        busy_polls = '0;
                        return begin_wait(seq_cfg.settle_wait, res);
                    end
                    SEQ_POLL_WRITE: begin
                        seq_phase = SEQ_POLL_READ;
                        res = request_reply(1'b1, LEN_STATUS, '0);
                    end
                    SEQ_POLL_READ: begin
                        if (!ev.payload[7]) begin
                            seq_phase = SEQ_DATA;
                            res = request_reply(1'b1, LEN_DATA, '0);
                            return 1'b1;
                        end
                        busy_polls = busy_polls + 4'd1;
                        if (busy_polls == 0 || busy_polls >= seq_cfg.max_polls) begin
                            res = end_reading(OUTCOME_TIMEOUT);
                            return 1'b1;
                        end
                        return begin_wait(seq_cfg.poll_interval, res);
                    end
                    default: res = convert_reading(ev.payload);
                endcase
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic check_field(string field, logic signed [63:0] want,
                               logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // input side: offer queued events, predict each accepted transaction
    always @(posedge i_clk) begin
        t_sensor_reply reply;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (predict_sequencer_reply(offered_event, reply))
                    predicted_replies.push_back(reply);
                events_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 7);
                    i_in_valid <= 1'b0;
                end else if (queued_events.size() != 0) begin
                    offered_event = queued_events.pop_front();
                    i_cmd        <= offered_event.cmd;
                    i_xfer_ok    <= offered_event.ok;
                    i_read_bytes <= offered_event.payload;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side stall: random bursts, plus one long hold-off under load
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (pressure_phase && !pressure_done) begin
            pressure_done = 1'b1;
            hold_left = 150;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_sensor_reply seen;
        t_sensor_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = '{o_kind, o_req_is_read, o_req_length, o_req_address, o_req_write_bytes,
                     o_outcome, o_humidity_tenths, o_celsius_tenths, o_fahrenheit_tenths,
                     o_frame_humidity_byte, o_frame_celsius_byte, o_frame_fahrenheit_byte};
            if (predicted_replies.size() == 0) begin
                $display("%0t unexpected transaction: expected none, actual kind %0d outcome %0d",
                         $time, seen.kind, seen.outcome);
                mismatches++;
            end else begin
                want = predicted_replies.pop_front();
                check_field("kind", want.kind, seen.kind);
                check_field("req_is_read", want.is_read, seen.is_read);
                check_field("req_length", want.length, seen.length);
                check_field("req_address", want.address, seen.address);
                check_field("req_write_bytes", want.write_bytes, seen.write_bytes);
                check_field("outcome", want.outcome, seen.outcome);
                check_field("humidity_tenths", want.humidity, seen.humidity);
                check_field("celsius_tenths", $signed(want.celsius), $signed(seen.celsius));
                check_field("fahrenheit_tenths", $signed(want.fahrenheit),
                            $signed(seen.fahrenheit));
                check_field("frame_humidity_byte", want.humidity_byte, seen.humidity_byte);
                check_field("frame_celsius_byte", want.celsius_byte, seen.celsius_byte);
                check_field("frame_fahrenheit_byte", want.fahrenheit_byte,
                            seen.fahrenheit_byte);
            end
        end
    end

    function automatic logic [47:0] random_bytes();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[47:0];
    endfunction

    function automatic void queue_event(logic [1:0] cmd, logic ok, logic [47:0] payload,
                                        bit counted);
        queued_events.push_back('{cmd, ok, payload});
        events_queued++;
        if (counted)
            planned_events++;
    endfunction

    function automatic void queue_done(logic [47:0] payload);
        queue_event(CMD_DONE, 1'b1, payload, 1'b1);
    endfunction

    // sprinkle events the sequencer must drop while a reading is under way
    function automatic void maybe_noise(bit in_wait);
        if ($urandom_range(0, 9) != 0)
            return;
        case ($urandom_range(0, 2))
            0: queue_event(CMD_NONE, 1'($urandom_range(0, 1)), random_bytes(), 1'b0);
            1: queue_event(CMD_START, 1'($urandom_range(0, 1)), random_bytes(), 1'b0);
            default: queue_event(in_wait ? CMD_DONE : CMD_TICK, 1'($urandom_range(0, 1)),
                                 random_bytes(), 1'b0);
        endcase
    endfunction

    function automatic bit transfer_fails(int fail_pct);
        if ($urandom_range(0, 99) >= fail_pct)
            return 1'b0;
        queue_event(CMD_DONE, 1'b0, random_bytes(), 1'b1);
        return 1'b1;
    endfunction

    function automatic void queue_ticks(logic [7:0] count);
        int i;
        for (i = 0; i < count; i++) begin
            maybe_noise(1'b1);
            queue_event(CMD_TICK, 1'($urandom_range(0, 1)), random_bytes(), 1'b1);
        end
    endfunction

    // one well-formed reading with random content, cut short by a bus error at times
    function automatic void queue_reading(int busy_pct, int fail_pct);
        int          stage;
        logic [3:0]  polls;
        logic [47:0] payload;
        bit          busy;
        queue_event(CMD_START, 1'($urandom_range(0, 1)), random_bytes(), 1'b1);
        for (stage = 0; stage < 3; stage++) begin
            maybe_noise(1'b0);
            if (transfer_fails(fail_pct))
                return;
            queue_done(random_bytes());
        end
        queue_ticks(plan.settle_wait);
        polls = '0;
        forever begin
            maybe_noise(1'b0);
            if (transfer_fails(fail_pct))
                return;
            queue_done(random_bytes());
            maybe_noise(1'b0);
            if (transfer_fails(fail_pct))
                return;
            busy = ($urandom_range(1, 100) <= busy_pct);
            payload = random_bytes();
            payload[7] = busy;
            queue_done(payload);
            if (!busy)
                break;
            polls = polls + 4'd1;
            if (polls == 0 || polls >= plan.max_polls)
                return;
            queue_ticks(plan.poll_interval);
        end
        maybe_noise(1'b0);
        if (transfer_fails(fail_pct))
            return;
        case ($urandom_range(0, 9))
            0: payload = '0;
            1: payload = '1;
            default: payload = random_bytes();
        endcase
        queue_done(payload);
    endfunction

    task automatic write_register(logic [1:0] idx, logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DEVICE_ADDRESS: seq_cfg.device_address = value[6:0];
            CFG_SETTLE_WAIT:    seq_cfg.settle_wait    = value;
            CFG_POLL_INTERVAL:  seq_cfg.poll_interval  = value;
            default:            seq_cfg.max_polls      = value[3:0];
        endcase
    endtask

    task automatic load_settings(logic [6:0] addr, logic [7:0] settle, logic [7:0] interval,
                                 logic [3:0] max_polls);
        write_register(CFG_DEVICE_ADDRESS, {1'b0, addr});
        write_register(CFG_SETTLE_WAIT, settle);
        write_register(CFG_POLL_INTERVAL, interval);
        write_register(CFG_MAX_POLLS, {4'd0, max_polls});
        plan = '{addr, settle, interval, max_polls};
    endtask

    // hold until every event is taken and every reply is back, then let the pipe empty
    task automatic wait_until_quiet();
        int guard;
        do @(posedge i_clk); while (events_accepted != events_queued);
        guard = 0;
        while (predicted_replies.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        if (predicted_replies.size() != 0) begin
            $display("%0t missing transactions: expected %0d more, actual none",
                     $time, predicted_replies.size());
            mismatches++;
            predicted_replies.delete();
        end
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        int readings;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ignored codes, busy start, zero settle, instant timeout, bus error
        load_settings(7'd127, 8'd0, 8'd0, 4'd0);
        queue_event(CMD_NONE, 1'b1, '1, 1'b1);
        queue_event(CMD_TICK, 1'b0, '0, 1'b1);
        queue_event(CMD_DONE, 1'b1, '1, 1'b1);
        queue_event(CMD_START, 1'b0, '0, 1'b1);
        queue_event(CMD_START, 1'b1, '1, 1'b1);
        queue_done('1);
        queue_event(CMD_TICK, 1'b1, '1, 1'b1);
        queue_done('0);
        queue_done('1);
        queue_done('0);
        queue_done('1);
        queue_event(CMD_START, 1'b1, '0, 1'b1);
        queue_event(CMD_DONE, 1'b0, '0, 1'b1);
        queue_event(CMD_START, 1'b1, '1, 1'b1);
        queue_done('1);
        queue_done('0);
        queue_done('1);
        queue_done('1);
        queue_done('0);
        queue_done('1);
        wait_until_quiet();

        // longest settle, then longest poll interval up to a timeout
        load_settings(7'd0, 8'd255, 8'd1, 4'd15);
        queue_reading(30, 0);
        wait_until_quiet();
        load_settings(7'd127, 8'd2, 8'd255, 4'd2);
        queue_reading(100, 0);
        wait_until_quiet();

        // zero waits give a reply per event: the output hold-off backs up the input
        load_settings(7'd56, 8'd0, 8'd0, 4'd15);
        pressure_phase = 1'b1;
        repeat (8) queue_reading(70, 3);
        wait_until_quiet();
        pressure_phase = 1'b0;

        while (planned_events < 850) begin
            calm = (planned_events >= 740);
            load_settings(7'($urandom_range(0, 127)), 8'($urandom_range(0, 6)),
                          8'($urandom_range(0, 4)), 4'($urandom_range(1, 15)));
            readings = $urandom_range(3, 6);
            repeat (readings) queue_reading($urandom_range(20, 80), 3);
            wait_until_quiet();
        end

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- humidity_sensor_read_sequencer_top.f -----
+incdir+design
design/hsrs_pkg.sv
design/hsrs_ctrl.sv
design/hsrs_conv.sv
design/humidity_sensor_read_sequencer_top.sv
design/hsrs_checker.sv
dv/humidity_sensor_read_sequencer_top_test.sv
